[hw/rtl/single_source_shortest_path_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the shortest path block
// Concurrent checks sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SINGLE_SOURCE_SHORTEST_PATH_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_ASSERT_SVH

// same-cycle implication
`define SSSP_ASSERT_IMP(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("sssp check failed");

// next-cycle implication
`define SSSP_ASSERT_NEXT(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("sssp check failed");

`endif

[hw/rtl/sssp_pkg.sv]
// ----------------------------------------------------------------------------
// sssp_pkg
// Field widths, configuration codes and storage types of the shortest path block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sssp_pkg;

  localparam int VERTEX_W = 6;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 32;
  localparam int VCOUNT_W = 7;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
  localparam logic [VERTEX_W-1:0] SOURCE_RESET = 6'd0;

  // configuration register indexes
  localparam logic CFG_VERTEX_COUNT  = 1'b0;
  localparam logic CFG_SOURCE_VERTEX = 1'b1;

  typedef struct packed {
    logic [VERTEX_W-1:0]        from_v;
    logic [VERTEX_W-1:0]        to_v;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DIST_W-1:0] val;
  } dist_t;

endpackage

[hw/rtl/sssp_ram.sv]
// ----------------------------------------------------------------------------
// sssp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read, old data on collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/single_source_shortest_path.sv]
// ----------------------------------------------------------------------------
// single_source_shortest_path
// Bellman-Ford shortest paths over a streamed list of directed weighted edges.
// ----------------------------------------------------------------------------
// Usage:
//   Edges enter on the in_ channel, one transfer per cycle while loading.
//   The transfer with in_last_edge set ends the graph; edges beyond MAX_EDGES
//   are dropped, the last one still starts the run. in_ready stays low
//   until every result of that graph has been taken.
//   Run after the last edge, with n vertices and E stored edges:
//     the distance memory is initialized, one vertex at a time,
//     then n passes over the edges follow when E > 0; each edge takes a read
//     of the edge memory, a read of both distance copies, a saturating add
//     and a compare/write-back (states S_DIST, S_ADD and S_CMP).
//   Results leave on the out_ channel in vertex order; each one takes a
//   distance memory read, then is held until the receiver takes it.
//   A stalled receiver simply holds the current result; nothing is lost.
//   cfg_ writes are taken in any cycle but only used at the last edge.
//   Reset (rst_n low, synchronous) empties the edge store and sets
//   vertex_count to 64 and source_vertex to 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "single_source_shortest_path_assert.svh"

module single_source_shortest_path #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [sssp_pkg::VCOUNT_W-1:0]       cfg_wdata,
  // edge input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sssp_pkg::VERTEX_W-1:0]       in_from_vertex,
  input  logic [sssp_pkg::VERTEX_W-1:0]       in_to_vertex,
  input  logic signed [sssp_pkg::WEIGHT_W-1:0] in_weight,
  input  logic                                in_last_edge,
  // result output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sssp_pkg::VERTEX_W-1:0]       out_vertex_index,
  output logic signed [sssp_pkg::DIST_W-1:0]  out_path_length,
  output logic                                out_reachable,
  output logic                                out_last_result
);

  import sssp_pkg::*;

  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W = $clog2(MAX_EDGES + 1);
  localparam int VA_W = $clog2(MAX_VERTICES);
  localparam int NV_W = $clog2(MAX_VERTICES + 1);
  localparam int EDGE_W = $bits(edge_t);
  localparam int DENT_W = $bits(dist_t);

  typedef enum logic [2:0] {
    S_LOAD, S_INIT, S_FETCH, S_DIST, S_ADD, S_CMP, S_OUT_RD, S_OUT_SEND
  } state_t;

  state_t state_r, state_nxt;

  logic [VCOUNT_W-1:0] vcount_r, vcount_nxt;
  logic [VERTEX_W-1:0] source_r, source_nxt;
  logic [EC_W-1:0]     edge_count_r, edge_count_nxt;
  logic [NV_W-1:0]     n_r, n_nxt;
  logic [VERTEX_W-1:0] src_r, src_nxt;
  logic                src_ok_r, src_ok_nxt;
  logic [NV_W-1:0]     k_r, k_nxt;
  logic [EC_W-1:0]     e_cnt_r, e_cnt_nxt;
  logic [NV_W-1:0]     pass_r, pass_nxt;

  // per-edge datapath registers
  logic                       edge_ok_r, edge_ok_nxt;
  logic [VA_W-1:0]            v_r, v_nxt;
  logic signed [WEIGHT_W-1:0] w_r, w_nxt;
  logic                       relax_ok_r, relax_ok_nxt;
  logic signed [DIST_W-1:0]   cand_r, cand_nxt;
  logic                       dv_ok_r, dv_ok_nxt;
  logic signed [DIST_W-1:0]   dv_val_r, dv_val_nxt;

  // memory ports
  logic            edge_we;
  edge_t           edge_wdata, edge_rdata;
  logic [EDGE_W-1:0] edge_rbits;
  logic            dist_we;
  logic [VA_W-1:0] dist_waddr, dist_raddr_a, dist_raddr_b;
  dist_t           dist_wdata, dist_a, dist_b;
  logic [DENT_W-1:0] dist_a_bits, dist_b_bits;

  logic in_xfer, out_xfer;
  logic [VCOUNT_W-1:0] vcount_eff;
  logic [VCOUNT_W-1:0] n_ext;
  logic signed [DIST_W:0] sum_wide;
  logic signed [DIST_W-1:0] sum_sat;
  logic k_last, e_done, relax_hit;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT_SEND);

  assign edge_rdata = edge_t'(edge_rbits);
  assign dist_a     = dist_t'(dist_a_bits);
  assign dist_b     = dist_t'(dist_b_bits);
  assign n_ext      = VCOUNT_W'(n_r);

  // effective vertex count: zero reads as one, clamp at the store size
  always_comb begin
    priority if (vcount_r == '0) begin
      vcount_eff = VCOUNT_W'(1);
    end else if (vcount_r > VCOUNT_W'(MAX_VERTICES)) begin
      vcount_eff = VCOUNT_W'(MAX_VERTICES);
    end else begin
      vcount_eff = vcount_r;
    end
  end

  // saturating add of tail distance and weight
  assign sum_wide = {dist_a.val[DIST_W-1], dist_a.val}
                  + (DIST_W+1)'(w_r);
  always_comb begin
    if (sum_wide[DIST_W] != sum_wide[DIST_W-1]) begin
      sum_sat = sum_wide[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}}
                                 : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[DIST_W-1:0];
    end
  end

  assign k_last    = (NV_W'(k_r + 1'b1) == n_r);
  assign e_done    = (e_cnt_r == edge_count_r);
  assign relax_hit = relax_ok_r && (!dv_ok_r || (cand_r < dv_val_r));

  // edge store write at the fill count
  assign edge_we          = in_xfer && (edge_count_r < EC_W'(MAX_EDGES));
  assign edge_wdata.from_v = in_from_vertex;
  assign edge_wdata.to_v   = in_to_vertex;
  assign edge_wdata.weight = in_weight;

  // distance store: init sweep or relaxation write-back
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = k_r[VA_W-1:0];
    dist_wdata.ok  = src_ok_r && (VCOUNT_W'(k_r) == VCOUNT_W'(src_r));
    dist_wdata.val = '0;
    if (state_r == S_INIT) begin
      dist_we = 1'b1;
    end else if (state_r == S_CMP) begin
      dist_we        = relax_hit;
      dist_waddr     = v_r;
      dist_wdata.ok  = 1'b1;
      dist_wdata.val = cand_r;
    end
  end

  assign dist_raddr_a = (state_r == S_DIST) ? edge_rdata.from_v[VA_W-1:0]
                                            : k_r[VA_W-1:0];
  assign dist_raddr_b = edge_rdata.to_v[VA_W-1:0];

  // distance and reachable flag come straight from the registered memory read
  assign out_vertex_index = VERTEX_W'(k_r[VA_W-1:0]);
  assign out_reachable    = dist_a.ok;
  assign out_path_length  = dist_a.ok ? dist_a.val : '0;
  assign out_last_result  = k_last;

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    vcount_nxt     = vcount_r;
    source_nxt     = source_r;
    edge_count_nxt = edge_count_r;
    n_nxt          = n_r;
    src_nxt        = src_r;
    src_ok_nxt     = src_ok_r;
    k_nxt          = k_r;
    e_cnt_nxt      = e_cnt_r;
    pass_nxt       = pass_r;
    edge_ok_nxt    = edge_ok_r;
    v_nxt          = v_r;
    w_nxt          = w_r;
    relax_ok_nxt   = relax_ok_r;
    cand_nxt       = cand_r;
    dv_ok_nxt      = dv_ok_r;
    dv_val_nxt     = dv_val_r;

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT:  vcount_nxt = cfg_wdata;
        CFG_SOURCE_VERTEX: source_nxt = cfg_wdata[VERTEX_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (edge_we) begin
            edge_count_nxt = EC_W'(edge_count_r + 1'b1);
          end
          if (in_last_edge) begin
            n_nxt      = NV_W'(vcount_eff);
            src_nxt    = source_r;
            src_ok_nxt = (VCOUNT_W'(source_r) < vcount_eff);
            k_nxt      = '0;
            state_nxt  = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (k_last) begin
          k_nxt     = '0;
          e_cnt_nxt = '0;
          pass_nxt  = '0;
          state_nxt = (edge_count_r == '0) ? S_OUT_RD : S_FETCH;
        end else begin
          k_nxt = NV_W'(k_r + 1'b1);
        end
      end
      S_FETCH: begin
        state_nxt = S_DIST;
      end
      S_DIST: begin
        edge_ok_nxt = (VCOUNT_W'(edge_rdata.from_v) < n_ext)
                   && (VCOUNT_W'(edge_rdata.to_v) < n_ext);
        v_nxt       = edge_rdata.to_v[VA_W-1:0];
        w_nxt       = edge_rdata.weight;
        e_cnt_nxt   = EC_W'(e_cnt_r + 1'b1);
        state_nxt   = S_ADD;
      end
      S_ADD: begin
        relax_ok_nxt = edge_ok_r && dist_a.ok;
        cand_nxt     = sum_sat;
        dv_ok_nxt    = dist_b.ok;
        dv_val_nxt   = dist_b.val;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        if (e_done) begin
          if (NV_W'(pass_r + 1'b1) == n_r) begin
            k_nxt     = '0;
            state_nxt = S_OUT_RD;
          end else begin
            pass_nxt  = NV_W'(pass_r + 1'b1);
            e_cnt_nxt = '0;
            state_nxt = S_FETCH;
          end
        end else begin
          state_nxt = S_DIST;
        end
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_SEND;
      end
      S_OUT_SEND: begin
        if (out_xfer) begin
          if (k_last) begin
            edge_count_nxt = '0;
            state_nxt      = S_LOAD;
          end else begin
            k_nxt     = NV_W'(k_r + 1'b1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      vcount_r     <= VCOUNT_RESET;
      source_r     <= SOURCE_RESET;
      edge_count_r <= '0;
      n_r          <= '0;
      src_r        <= '0;
      src_ok_r     <= 1'b0;
      k_r          <= '0;
      e_cnt_r      <= '0;
      pass_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      vcount_r     <= vcount_nxt;
      source_r     <= source_nxt;
      edge_count_r <= edge_count_nxt;
      n_r          <= n_nxt;
      src_r        <= src_nxt;
      src_ok_r     <= src_ok_nxt;
      k_r          <= k_nxt;
      e_cnt_r      <= e_cnt_nxt;
      pass_r       <= pass_nxt;
    end
    edge_ok_r  <= edge_ok_nxt;
    v_r        <= v_nxt;
    w_r        <= w_nxt;
    relax_ok_r <= relax_ok_nxt;
    cand_r     <= cand_nxt;
    dv_ok_r    <= dv_ok_nxt;
    dv_val_r   <= dv_val_nxt;
  end

  // edge store
  sssp_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_count_r[EA_W-1:0]),
    .wdata (edge_wdata),
    .raddr (e_cnt_r[EA_W-1:0]),
    .rdata (edge_rbits)
  );

  // distance store, two identical copies for tail and head reads
  sssp_ram #(
    .WIDTH (DENT_W),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram_a (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr_a),
    .rdata (dist_a_bits)
  );

  sssp_ram #(
    .WIDTH (DENT_W),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram_b (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr_b),
    .rdata (dist_b_bits)
  );

  // checks
  `SSSP_ASSERT_IMP(a_fill_bound, 1'b1, edge_count_r <= EC_W'(MAX_EDGES))
  `SSSP_ASSERT_IMP(a_out_in_range, out_valid, k_r < n_r)
  `SSSP_ASSERT_IMP(a_write_in_range, dist_we, VCOUNT_W'(dist_waddr) < n_ext)
  `SSSP_ASSERT_NEXT(a_last_out_reload, out_xfer && out_last_result,
                    in_ready && (edge_count_r == '0))
  `SSSP_ASSERT_NEXT(a_last_in_busy, in_xfer && in_last_edge, !in_ready && !out_valid)

endmodule
